[hdl/alkt_pkg.sv]
`timescale 1ns / 1ps

package alkt_pkg;

   localparam int DEPTH     = 16;
   localparam int KEY_WIDTH = 32;
   localparam int IDX_W     = $clog2(DEPTH);
   localparam int CNT_W     = $clog2(DEPTH + 1);
   localparam int CSR_IDX_W = 1;

   localparam logic [2:0] MODE_INSERT = 3'd0;
   localparam logic [2:0] MODE_FIND   = 3'd1;
   localparam logic [2:0] MODE_BUMP   = 3'd2;
   localparam logic [2:0] MODE_DELETE = 3'd3;
   localparam logic [2:0] MODE_TICK   = 3'd4;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [1:0] STATUS_FULL      = 2'd2;
   localparam logic [1:0] STATUS_EXPIRED   = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INTERVAL = 1'd1;

   localparam logic [31:0] TIMEOUT_RESET  = 32'd60;
   localparam logic [15:0] INTERVAL_RESET = 16'd1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SWEEP
   } state_type;

   typedef struct packed {
      logic                 match_en;
      logic [KEY_WIDTH-1:0] cmp_key;
      logic                 load;
      logic [IDX_W-1:0]     load_rank;
      logic [KEY_WIDTH-1:0] new_key;
      logic [31:0]          new_stamp;
      logic                 shift;
      logic [IDX_W-1:0]     shift_rank;
      logic [31:0]          now;
      logic [31:0]          timeout;
   } cell_ctrl_type;

endpackage

[hdl/aging_lru_key_table_unit.sv]
`timescale 1ns / 1ps
// Requests: a new request is accepted only while idle with the response slot free, so
// the block takes one request at a time; the request is registered, then executed.
// A sweeping tick gives one result beat per cycle from cell 0 while the receiver takes
// them, one per expired key removed, or a single OK beat when none expire.
// Reset (synchronous, active high): empties the table, clears the tick count and
// sweep countdown, restores timeout 60 and interval 1; entry contents stay undefined.

module aging_lru_key_table_unit import alkt_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [2:0]           req_mode,
   input  logic [31:0]          req_key,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_status,
   output logic [31:0]          rsp_key_out,
   output logic [3:0]           rsp_position,
   output logic [4:0]           rsp_occupancy,
   output logic [4:0]           rsp_removed_count,
   output logic                 rsp_last,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_write_data
);

   state_type state_ff, state_in;

   logic [31:0]      timeout_ff, timeout_in;
   logic [15:0]      interval_ff, interval_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [31:0]      now_ff, now_in;
   logic [15:0]      countdown_ff, countdown_in;
   logic [CNT_W-1:0] removed_ff, removed_in;
   logic [2:0]       mode_ff, mode_in;
   logic [31:0]      req_key_ff, req_key_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rsp_status_ff, rsp_status_in;
   logic [31:0]      rsp_key_ff, rsp_key_in;
   logic [3:0]       rsp_position_ff, rsp_position_in;
   logic [4:0]       rsp_occupancy_ff, rsp_occupancy_in;
   logic [4:0]       rsp_removed_ff, rsp_removed_in;
   logic             rsp_last_ff, rsp_last_in;

   cell_ctrl_type        ctrl;
   logic [KEY_WIDTH-1:0] key_w   [DEPTH];
   logic [31:0]          stamp_w [DEPTH];
   logic [DEPTH-1:0]     match_w;
   logic [DEPTH-1:0]     expired_w;
   logic                 hit;
   logic [IDX_W-1:0]     hit_rank;
   logic                 accept;
   logic                 slot_free;
   logic                 sweep_last;

   genvar g;
   generate
      for (g = 0; g < DEPTH; g++) begin : g_cell
         logic [KEY_WIDTH-1:0] nk;
         logic [31:0]          ns;
         if (g == DEPTH - 1) begin : g_tail
            assign nk = '0;
            assign ns = '0;
         end else begin : g_link
            assign nk = key_w[g + 1];
            assign ns = stamp_w[g + 1];
         end
         alkt_cell u_cell (
            .clock      (clock),
            .ctrl       (ctrl),
            .cell_index (IDX_W'(g)),
            .next_key   (nk),
            .next_stamp (ns),
            .key        (key_w[g]),
            .stamp      (stamp_w[g]),
            .match      (match_w[g]),
            .expired    (expired_w[g])
         );
      end
   endgenerate

   always_comb begin
      hit      = 1'b0;
      hit_rank = '0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (match_w[i] && (CNT_W'(i) < count_ff)) begin
            hit      = 1'b1;
            hit_rank = IDX_W'(i);
         end
      end
   end

   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign sweep_last = !((count_ff > CNT_W'(1)) && expired_w[1]);

   always_comb begin
      state_in     = state_ff;
      timeout_in   = timeout_ff;
      interval_in  = interval_ff;
      count_in     = count_ff;
      now_in       = now_ff;
      countdown_in = countdown_ff;
      removed_in   = removed_ff;
      mode_in      = mode_ff;
      req_key_in   = req_key_ff;

      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_status_in    = rsp_status_ff;
      rsp_key_in       = rsp_key_ff;
      rsp_position_in  = rsp_position_ff;
      rsp_occupancy_in = rsp_occupancy_ff;
      rsp_removed_in   = rsp_removed_ff;
      rsp_last_in      = rsp_last_ff;

      req_ready = (state_ff == ST_IDLE) && slot_free;
      accept    = req_valid && req_ready;

      ctrl            = '0;
      ctrl.match_en   = accept;
      ctrl.cmp_key    = req_key[KEY_WIDTH-1:0];
      ctrl.new_key    = req_key_ff[KEY_WIDTH-1:0];
      ctrl.new_stamp  = now_ff;
      ctrl.now        = now_ff;
      ctrl.timeout    = timeout_ff;

      if (csr_write_enable) begin
         case (csr_index)
            CSR_TIMEOUT:  timeout_in  = csr_write_data;
            CSR_INTERVAL: interval_in = csr_write_data[15:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               mode_in    = req_mode;
               req_key_in = req_key;
               state_in   = ST_EXEC;
            end
         end
         ST_EXEC: begin
            rsp_valid_in     = 1'b1;
            rsp_status_in    = STATUS_OK;
            rsp_key_in       = req_key_ff;
            rsp_position_in  = 4'(hit_rank);
            rsp_removed_in   = '0;
            rsp_last_in      = 1'b1;
            state_in         = ST_IDLE;
            case (mode_ff)
               MODE_INSERT: begin
                  if (count_ff >= CNT_W'(DEPTH)) begin
                     rsp_status_in   = STATUS_FULL;
                     rsp_position_in = '0;
                  end else begin
                     ctrl.load       = 1'b1;
                     ctrl.load_rank  = count_ff[IDX_W-1:0];
                     count_in        = count_ff + CNT_W'(1);
                     rsp_position_in = 4'(count_ff[IDX_W-1:0]);
                  end
               end
               MODE_FIND: begin
                  if (!hit) begin
                     rsp_status_in   = STATUS_NOT_FOUND;
                     rsp_position_in = '0;
                  end
               end
               MODE_BUMP: begin
                  if (!hit) begin
                     rsp_status_in   = STATUS_NOT_FOUND;
                     rsp_position_in = '0;
                  end else begin
                     ctrl.shift      = 1'b1;
                     ctrl.shift_rank = hit_rank;
                     ctrl.load       = 1'b1;
                     ctrl.load_rank  = IDX_W'(count_ff - CNT_W'(1));
                  end
               end
               MODE_DELETE: begin
                  if (!hit) begin
                     rsp_status_in   = STATUS_NOT_FOUND;
                     rsp_position_in = '0;
                  end else begin
                     ctrl.shift      = 1'b1;
                     ctrl.shift_rank = hit_rank;
                     count_in        = count_ff - CNT_W'(1);
                  end
               end
               MODE_TICK: begin
                  rsp_position_in = '0;
                  now_in          = now_ff + 32'd1;
                  if (countdown_ff inside {16'd0, 16'd1}) begin
                     countdown_in = interval_ff;
                     removed_in   = '0;
                     rsp_valid_in = 1'b0;
                     state_in     = ST_SWEEP;
                  end else begin
                     countdown_in = countdown_ff - 16'd1;
                  end
               end
               default: begin
                  rsp_status_in   = STATUS_NOT_FOUND;
                  rsp_position_in = '0;
               end
            endcase
            rsp_occupancy_in = 5'(count_in);
         end
         ST_SWEEP: begin
            if (slot_free) begin
               rsp_valid_in    = 1'b1;
               rsp_position_in = '0;
               if ((count_ff != '0) && expired_w[0]) begin
                  // drop the oldest entry and report it
                  ctrl.shift       = 1'b1;
                  ctrl.shift_rank  = '0;
                  count_in         = count_ff - CNT_W'(1);
                  removed_in       = removed_ff + CNT_W'(1);
                  rsp_status_in    = STATUS_EXPIRED;
                  rsp_key_in       = 32'(key_w[0]);
                  rsp_removed_in   = 5'(removed_in);
                  rsp_occupancy_in = 5'(count_in);
                  rsp_last_in      = sweep_last;
                  if (sweep_last) begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  rsp_status_in    = STATUS_OK;
                  rsp_key_in       = req_key_ff;
                  rsp_removed_in   = '0;
                  rsp_occupancy_in = 5'(count_ff);
                  rsp_last_in      = 1'b1;
                  state_in         = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         timeout_ff   <= TIMEOUT_RESET;
         interval_ff  <= INTERVAL_RESET;
         count_ff     <= '0;
         now_ff       <= '0;
         countdown_ff <= '0;
         removed_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         timeout_ff   <= timeout_in;
         interval_ff  <= interval_in;
         count_ff     <= count_in;
         now_ff       <= now_in;
         countdown_ff <= countdown_in;
         removed_ff   <= removed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff          <= mode_in;
      req_key_ff       <= req_key_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_key_ff       <= rsp_key_in;
      rsp_position_ff  <= rsp_position_in;
      rsp_occupancy_ff <= rsp_occupancy_in;
      rsp_removed_ff   <= rsp_removed_in;
      rsp_last_ff      <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_key_out       = rsp_key_ff;
   assign rsp_position      = rsp_position_ff;
   assign rsp_occupancy     = rsp_occupancy_ff;
   assign rsp_removed_count = rsp_removed_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

[hdl/alkt_cell.sv]
`timescale 1ns / 1ps

module alkt_cell import alkt_pkg::*; (
   input  logic                 clock,
   input  cell_ctrl_type        ctrl,
   input  logic [IDX_W-1:0]     cell_index,
   input  logic [KEY_WIDTH-1:0] next_key,
   input  logic [31:0]          next_stamp,
   output logic [KEY_WIDTH-1:0] key,
   output logic [31:0]          stamp,
   output logic                 match,
   output logic                 expired
);

   logic [KEY_WIDTH-1:0] key_ff, key_in;
   logic [31:0]          stamp_ff, stamp_in;
   logic                 match_ff, match_in;
   logic [31:0]          age;

   always_comb begin
      key_in   = key_ff;
      stamp_in = stamp_ff;
      match_in = match_ff;
      if (ctrl.load && (cell_index == ctrl.load_rank)) begin
         key_in   = ctrl.new_key;
         stamp_in = ctrl.new_stamp;
      end else if (ctrl.shift && (cell_index >= ctrl.shift_rank)) begin
         // advance the neighbor's entry one rank toward the oldest end
         key_in   = next_key;
         stamp_in = next_stamp;
      end
      if (ctrl.match_en) begin
         match_in = (key_ff == ctrl.cmp_key);
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      stamp_ff <= stamp_in;
      match_ff <= match_in;
   end

   assign age     = ctrl.now - stamp_ff;
   assign expired = (age >= ctrl.timeout);
   assign key     = key_ff;
   assign stamp   = stamp_ff;
   assign match   = match_ff;

endmodule

[tb/aging_lru_key_table_unit_tb.sv]
`timescale 1ns / 1ps

module aging_lru_key_table_unit_tb import alkt_pkg::*; ();

   localparam logic [2:0] MODE_RSVD_LO = 3'd5;
   localparam logic [2:0] MODE_RSVD_MID = 3'd6;
   localparam logic [2:0] MODE_RSVD_HI = 3'd7;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_CYCLES = 200;
   localparam int SETTLE_CYCLES = 8;
   localparam int TAIL_CYCLES = 20;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] key_out;
      logic [3:0]  position;
      logic [4:0]  occupancy;
      logic [4:0]  removed_count;
      logic        last;
   } response_type;

   typedef struct packed {
      logic [2:0]  mode;
      logic [31:0] key;
      logic        typed;
      logic [1:0]  status;
      logic [3:0]  position;
      logic [4:0]  occupancy;
   } directed_row_type;

   localparam directed_row_type DIRECTED_ROWS [13] = '{
      '{MODE_FIND,     32'h0000_0000, 1'b1, STATUS_NOT_FOUND, 4'd0, 5'd0},
      '{MODE_DELETE,   32'hFFFF_FFFF, 1'b1, STATUS_NOT_FOUND, 4'd0, 5'd0},
      '{MODE_RSVD_HI,  32'hA5A5_A5A5, 1'b1, STATUS_NOT_FOUND, 4'd0, 5'd0},
      '{MODE_TICK,     32'h5A5A_5A5A, 1'b1, STATUS_OK,        4'd0, 5'd0},
      '{MODE_INSERT,   32'h0000_0000, 1'b1, STATUS_OK,        4'd0, 5'd1},
      '{MODE_INSERT,   32'hFFFF_FFFF, 1'b1, STATUS_OK,        4'd1, 5'd2},
      '{MODE_INSERT,   32'h0000_0000, 1'b1, STATUS_OK,        4'd2, 5'd3},
      '{MODE_FIND,     32'h0000_0000, 1'b1, STATUS_OK,        4'd0, 5'd3},
      '{MODE_BUMP,     32'h0000_0000, 1'b0, STATUS_OK,        4'd0, 5'd0},
      '{MODE_FIND,     32'h0000_0000, 1'b0, STATUS_OK,        4'd0, 5'd0},
      '{MODE_DELETE,   32'h0000_0000, 1'b0, STATUS_OK,        4'd0, 5'd0},
      '{MODE_BUMP,     32'hDEAD_BEEF, 1'b1, STATUS_NOT_FOUND, 4'd0, 5'd2},
      '{MODE_RSVD_LO,  32'h0000_0000, 1'b1, STATUS_NOT_FOUND, 4'd0, 5'd2}
   };

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [2:0]           req_mode;
   logic [31:0]          req_key;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [1:0]           rsp_status;
   logic [31:0]          rsp_key_out;
   logic [3:0]           rsp_position;
   logic [4:0]           rsp_occupancy;
   logic [4:0]           rsp_removed_count;
   logic                 rsp_last;
   logic                 csr_write_enable;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [31:0]          csr_write_data;

   logic [31:0] tbl_keys [DEPTH];
   logic [31:0] tbl_stamps [DEPTH];
   int          tbl_count = 0;
   logic [31:0] tick_now = '0;
   logic [15:0] sweep_wait = '0;
   logic [31:0] cfg_timeout = TIMEOUT_RESET;
   logic [15:0] cfg_interval = INTERVAL_RESET;

   response_type pending_responses [$];
   int        failures = 0;
   int        idle_cycles = 0;
   int        burst_left = 0;
   bit        hold_request = 0;

   aging_lru_key_table_unit DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_key           (req_key),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_key_out       (rsp_key_out),
      .rsp_position      (rsp_position),
      .rsp_occupancy     (rsp_occupancy),
      .rsp_removed_count (rsp_removed_count),
      .rsp_last          (rsp_last),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void append_entry(input logic [31:0] key);
      tbl_keys[tbl_count] = key;
      tbl_stamps[tbl_count] = tick_now;
      tbl_count++;
   endfunction

   function automatic void drop_entry(input int rank);
      for (int i = rank; i + 1 < tbl_count; i++) begin
         tbl_keys[i] = tbl_keys[i + 1];
         tbl_stamps[i] = tbl_stamps[i + 1];
      end
      tbl_count--;
   endfunction

   function automatic string show(input response_type r);
      return $sformatf("status=%0d key=%h pos=%0d occ=%0d removed=%0d last=%0d",
                       r.status, r.key_out, r.position, r.occupancy, r.removed_count, r.last);
   endfunction

   task automatic log_failure(input string msg);
      failures++;
      if (failures <= 10) $display("%0t: %s", $time, msg);
   endtask

   task automatic predict_key_table(input logic [2:0] mode, input logic [31:0] key,
                                    input bit typed, input logic [1:0] t_status,
                                    input logic [3:0] t_position, input logic [4:0] t_occupancy);
      response_type outcome [$];
      response_type rsp;
      logic [31:0]  gone;
      int           rank;
      int           expiring;
      rank = -1;
      expiring = 0;
      rsp = {STATUS_OK, key, 4'd0, 5'd0, 5'd0, 1'b1};
      for (int i = 0; i < tbl_count; i++)
         if (rank < 0 && tbl_keys[i] == key) rank = i;
      case (mode)
         MODE_INSERT: begin
            if (tbl_count >= DEPTH) rsp.status = STATUS_FULL;
            else begin
               rsp.position = 4'(tbl_count);
               append_entry(key);
            end
         end
         MODE_FIND, MODE_BUMP, MODE_DELETE: begin
            if (rank < 0) rsp.status = STATUS_NOT_FOUND;
            else begin
               rsp.position = 4'(rank);
               if (mode != MODE_FIND) drop_entry(rank);
               if (mode == MODE_BUMP) append_entry(key);
            end
         end
         MODE_TICK: begin
            tick_now = tick_now + 32'd1;
            if (sweep_wait <= 16'd1) begin
               sweep_wait = cfg_interval;
               while (expiring < tbl_count && tick_now - tbl_stamps[expiring] >= cfg_timeout)
                  expiring++;
            end else sweep_wait = sweep_wait - 16'd1;
            for (int i = 0; i < expiring; i++) begin
               gone = tbl_keys[0];
               drop_entry(0);
               outcome.push_back({STATUS_EXPIRED, gone, 4'd0, 5'(tbl_count), 5'(i + 1),
                                  i == expiring - 1});
            end
         end
         default: rsp.status = STATUS_NOT_FOUND;
      endcase
      if (expiring == 0) begin
         rsp.occupancy = 5'(tbl_count);
         outcome.push_back(rsp);
      end
      if (typed) pending_responses.push_back({t_status, key, t_position, t_occupancy, 5'd0, 1'b1});
      else foreach (outcome[i]) pending_responses.push_back(outcome[i]);
   endtask

   task automatic issue_request(input logic [2:0] mode, input logic [31:0] key, input bit steady,
                                input bit typed, input logic [1:0] t_status,
                                input logic [3:0] t_position, input logic [4:0] t_occupancy);
      int gap;
      @(negedge clock);
      if (!steady && burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      if (burst_left > 0) burst_left--;
      req_valid <= 1'b1;
      req_mode <= mode;
      req_key <= key;
      do @(posedge clock); while (req_ready !== 1'b1);
      predict_key_table(mode, key, typed, t_status, t_position, t_occupancy);
   endtask

   task automatic drain_table_traffic();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_TIMEOUT) cfg_timeout = data;
      else cfg_interval = data[15:0];
   endtask

   task automatic settle_and_configure(input logic [31:0] timeout, input logic [31:0] interval);
      drain_table_traffic();
      write_csr(CSR_TIMEOUT, timeout);
      write_csr(CSR_INTERVAL, interval);
   endtask

   task automatic run_random_phase(input int n_items, input bit steady);
      logic [31:0] key_pool [6];
      logic [2:0]  mode;
      logic [31:0] key;
      int          pick;
      foreach (key_pool[i]) key_pool[i] = $urandom;
      if ($urandom_range(0, 3) == 0) key_pool[0] = '0;
      if ($urandom_range(0, 3) == 0) key_pool[1] = '1;
      for (int n = 0; n < n_items; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 30) mode = MODE_INSERT;
         else if (pick < 45) mode = MODE_FIND;
         else if (pick < 60) mode = MODE_BUMP;
         else if (pick < 75) mode = MODE_DELETE;
         else if (pick < 95) mode = MODE_TICK;
         else mode = 3'($urandom_range(MODE_RSVD_LO, MODE_RSVD_HI));
         key = ($urandom_range(0, 3) == 0) ? $urandom : key_pool[$urandom_range(0, 5)];
         issue_request(mode, key, steady, 1'b0, STATUS_OK, 4'd0, 5'd0);
      end
   endtask

   initial begin
      int seg_len;
      int kind;
      rsp_ready = 1'b0;
      forever begin
         if (hold_request) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 0;
         end
         kind = $urandom_range(0, 3);
         seg_len = (kind == 1) ? $urandom_range(1, 12) : $urandom_range(1, 30);
         for (int c = 0; c < seg_len; c++) begin
            @(negedge clock);
            case (kind)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= 1'b0;
               2: rsp_ready <= c[0];
               default: rsp_ready <= 1'($urandom_range(0, 1));
            endcase
         end
      end
   end

   always @(posedge clock) begin
      response_type got;
      response_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         got = {rsp_status, rsp_key_out, rsp_position, rsp_occupancy, rsp_removed_count, rsp_last};
         if (pending_responses.size() == 0) log_failure({"unexpected beat: ", show(got)});
         else begin
            want = pending_responses.pop_front();
            if (got !== want)
               log_failure({"mismatch: expected ", show(want), " got ", show(got)});
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid === 1'b1 && req_ready === 1'b1) || (rsp_valid === 1'b1 && rsp_ready === 1'b1))
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_mode = MODE_INSERT;
      req_key = '0;
      csr_write_enable = 1'b0;
      csr_index = CSR_TIMEOUT;
      csr_write_data = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[i])
         issue_request(DIRECTED_ROWS[i].mode, DIRECTED_ROWS[i].key, 1'b0, DIRECTED_ROWS[i].typed,
                       DIRECTED_ROWS[i].status, DIRECTED_ROWS[i].position,
                       DIRECTED_ROWS[i].occupancy);
      while (tbl_count < DEPTH)
         issue_request(MODE_INSERT, $urandom, 1'b0, 1'b0, STATUS_OK, 4'd0, 5'd0);
      issue_request(MODE_INSERT, 32'h0BAD_F00D, 1'b0, 1'b1, STATUS_FULL, 4'd0, 5'(DEPTH));

      // zero timeout and zero interval: a full table expires on one tick
      settle_and_configure(32'd0, 32'd0);
      issue_request(MODE_TICK, $urandom, 1'b0, 1'b0, STATUS_OK, 4'd0, 5'd0);
      run_random_phase(40, 1'b0);

      settle_and_configure(32'd1, 32'd1);
      run_random_phase(56, 1'b0);
      settle_and_configure(32'd4, 32'd2);
      run_random_phase(56, 1'b0);
      settle_and_configure(32'd7, 32'd3);
      run_random_phase(56, 1'b0);
      settle_and_configure(32'hFFFF_FFFF, 32'h0000_FFFF);
      run_random_phase(56, 1'b0);
      settle_and_configure($urandom_range(2, 12), $urandom_range(1, 4));
      run_random_phase(56, 1'b0);

      // hold the receiver off while requests keep coming
      settle_and_configure(32'd3, 32'd1);
      hold_request = 1;
      run_random_phase(40, 1'b1);
      run_random_phase(20, 1'b0);

      settle_and_configure(TIMEOUT_RESET, 32'(INTERVAL_RESET));
      run_random_phase(56, 1'b0);

      drain_table_traffic();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (failures == 0 && pending_responses.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
